[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[design/bie_pkg.sv]
package bie_pkg;

  localparam int MAX_IN_WIDTH  = 256;
  localparam int MAX_IN_HEIGHT = 256;
  localparam int FRAC_BITS     = 16;
  localparam int OUT_MAX       = 4096;

  localparam int CFG_IN_W   = 9;
  localparam int CFG_OUT_W  = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int PX_W       = 12;
  localparam int SAMPLE_W   = 16;

  localparam int COL_W  = $clog2(MAX_IN_WIDTH);
  localparam int ROW_W  = $clog2(MAX_IN_HEIGHT);
  localparam int DEPTH  = MAX_IN_WIDTH * MAX_IN_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int PROD_W    = PX_W + CFG_IN_W;
  localparam int NUM_W     = PROD_W + FRAC_BITS;
  localparam int DIV_STEPS = 4;
  localparam int DIV_CYC   = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_W     = DIV_CYC * DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_CYC);
  localparam int REM_W     = CFG_OUT_W + 1;
  localparam int IP_W      = DIV_W - FRAC_BITS;

  localparam int WGT_W     = FRAC_BITS + 1;
  localparam int ROW_SUM_W = FRAC_BITS + SAMPLE_W;
  localparam int SUM_W     = 2 * FRAC_BITS + SAMPLE_W;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_REQ  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH,
    REG_IN_HEIGHT,
    REG_OUT_WIDTH,
    REG_OUT_HEIGHT
  } cfg_reg_e;

  // dividend bits shift out the top while quotient bits shift in the bottom
  typedef struct packed {
    logic [DIV_W-1:0] nq;
    logic [REM_W-1:0] rem;
  } div_t;

  typedef struct packed {
    logic [CFG_IN_W-1:0]  i0;
    logic [CFG_IN_W-1:0]  i1;
    logic [FRAC_BITS-1:0] frac;
  } pos_t;

  function automatic div_t div_steps(div_t s, logic [CFG_OUT_W-1:0] d);
    div_t             r;
    logic [REM_W-1:0] trial;
    logic             qbit;
    r = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {r.rem[REM_W-2:0], r.nq[DIV_W-1]};
      qbit  = (trial >= {1'b0, d});
      r.rem = qbit ? (trial - {1'b0, d}) : trial;
      r.nq  = {r.nq[DIV_W-2:0], qbit};
    end
    return r;
  endfunction

  // integer part clamped to the last index (repeat edge), plus fraction
  function automatic pos_t pos_split(logic [DIV_W-1:0] q, logic [CFG_IN_W-1:0] n);
    pos_t                r;
    logic [IP_W-1:0]     ip;
    logic [IP_W:0]       ip1;
    logic [CFG_IN_W-1:0] last;
    ip     = q[DIV_W-1:FRAC_BITS];
    ip1    = {1'b0, ip} + (IP_W+1)'(1);
    last   = n - CFG_IN_W'(1);
    r.frac = q[FRAC_BITS-1:0];
    r.i0   = (ip > IP_W'(last)) ? last : ip[CFG_IN_W-1:0];
    r.i1   = (ip1 > (IP_W+1)'(last)) ? last : ip1[CFG_IN_W-1:0];
    return r;
  endfunction

endpackage

[design/bilinear_image_enlarge_unit.sv]
// Bilinear enlarger for one image plane held in an on-chip frame store.
// Input channel (in_valid_i / in_stall_o): func_i = 0 loads sample_i into
// the store at (px_i, py_i); loads outside the configured input size are
// dropped. func_i = 1 requests output pixel (px_i, py_i) and yields one word
// on the output channel (out_valid_o / out_stall_i).
// Config channel (cfg_valid_i / cfg_ready_o): cfg_index_i selects in_width,
// in_height, out_width, out_height; write only while the block is idle.
// A load is written as it is accepted, and the next word is taken in the
// following cycle. A request runs radix-16 long division for both source
// coordinates, a clamp step, four reads of the single-port frame store,
// the multiply states S_LAST, S_V0 and S_V1, and a step into the output
// register. The input channel stalls from acceptance until the request is
// done, so a new word is taken only after the last request has finished.
// A stalled result waits in the output register while the next word is
// taken; a finished request waits for that register to free.
// Reset returns the size registers to 256 and empties the pipeline; the
// frame store keeps no reset and must be loaded before it is read.
`include "assert_macros.svh"

module bilinear_image_enlarge_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic [bie_pkg::PX_W-1:0]          px_i,
  input  logic [bie_pkg::PX_W-1:0]          py_i,
  input  logic [bie_pkg::SAMPLE_W-1:0]      sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bie_pkg::SAMPLE_W-1:0]      out_sample_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bie_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bie_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_POS, S_RD, S_LAST, S_V0, S_V1, S_OUT
  } state_e;

  state_e                           state_q;
  logic [bie_pkg::DIV_CNT_W-1:0]    div_cnt_q;
  logic [1:0]                       rd_cnt_q;
  logic                             mem_vld_q;
  logic [1:0]                       mem_sel_q;
  logic                             out_valid_q;
  logic [bie_pkg::SAMPLE_W-1:0]     out_sample_q;

  logic [bie_pkg::CFG_IN_W-1:0]     in_width_q, in_height_q;
  logic [bie_pkg::CFG_OUT_W-1:0]    out_width_q, out_height_q;
  logic [bie_pkg::CFG_IN_W-1:0]     wi, hi;
  logic [bie_pkg::CFG_OUT_W-1:0]    wo, ho;

  logic                             in_acc;
  logic                             load_ok;
  logic [bie_pkg::PROD_W-1:0]       xprod, yprod;

  bie_pkg::div_t                    xdiv_q, ydiv_q;
  logic [bie_pkg::CFG_OUT_W-1:0]    wo_q, ho_q;
  logic [bie_pkg::CFG_IN_W-1:0]     wi_q, hi_q;
  bie_pkg::pos_t                    xp_q, yp_q;

  logic [bie_pkg::SAMPLE_W-1:0]     mem_q [bie_pkg::DEPTH];
  logic [bie_pkg::SAMPLE_W-1:0]     mem_rdata_q;
  logic [bie_pkg::ADDR_W-1:0]       mem_waddr, mem_raddr, mem_addr;
  logic [bie_pkg::COL_W-1:0]        rd_col;
  logic [bie_pkg::ROW_W-1:0]        rd_row;

  logic [bie_pkg::WGT_W-1:0]        wgt_h, wgt_v0;
  logic [bie_pkg::WGT_W+bie_pkg::SAMPLE_W-1:0]  hprod;
  logic [bie_pkg::ROW_SUM_W-1:0]    hacc_q, r0_q, r1_q;
  logic [bie_pkg::SUM_W-1:0]        vacc_q, vsum;
  logic [bie_pkg::SAMPLE_W-1:0]     res_q;

  // size clamps: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (in_width_q == '0) wi = bie_pkg::CFG_IN_W'(1);
    else if (in_width_q > bie_pkg::CFG_IN_W'(bie_pkg::MAX_IN_WIDTH))
      wi = bie_pkg::CFG_IN_W'(bie_pkg::MAX_IN_WIDTH);
    else wi = in_width_q;
    if (in_height_q == '0) hi = bie_pkg::CFG_IN_W'(1);
    else if (in_height_q > bie_pkg::CFG_IN_W'(bie_pkg::MAX_IN_HEIGHT))
      hi = bie_pkg::CFG_IN_W'(bie_pkg::MAX_IN_HEIGHT);
    else hi = in_height_q;
    if (out_width_q == '0) wo = bie_pkg::CFG_OUT_W'(1);
    else if (out_width_q > bie_pkg::CFG_OUT_W'(bie_pkg::OUT_MAX))
      wo = bie_pkg::CFG_OUT_W'(bie_pkg::OUT_MAX);
    else wo = out_width_q;
    if (out_height_q == '0) ho = bie_pkg::CFG_OUT_W'(1);
    else if (out_height_q > bie_pkg::CFG_OUT_W'(bie_pkg::OUT_MAX))
      ho = bie_pkg::CFG_OUT_W'(bie_pkg::OUT_MAX);
    else ho = out_height_q;
  end

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = (state_q != S_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;

  assign load_ok = in_acc && (func_i == bie_pkg::FUNC_LOAD)
                   && (px_i < bie_pkg::PX_W'(wi)) && (py_i < bie_pkg::PX_W'(hi));

  assign xprod = bie_pkg::PROD_W'(px_i) * bie_pkg::PROD_W'(wi);
  assign yprod = bie_pkg::PROD_W'(py_i) * bie_pkg::PROD_W'(hi);

  // frame store addressing, row major
  assign mem_waddr = bie_pkg::ADDR_W'(
      bie_pkg::ADDR_W'(py_i[bie_pkg::ROW_W-1:0])
      * bie_pkg::ADDR_W'(bie_pkg::MAX_IN_WIDTH)
      + bie_pkg::ADDR_W'(px_i[bie_pkg::COL_W-1:0]));
  assign rd_col = rd_cnt_q[0] ? xp_q.i1[bie_pkg::COL_W-1:0] : xp_q.i0[bie_pkg::COL_W-1:0];
  assign rd_row = rd_cnt_q[1] ? yp_q.i1[bie_pkg::ROW_W-1:0] : yp_q.i0[bie_pkg::ROW_W-1:0];
  assign mem_raddr = bie_pkg::ADDR_W'(
      bie_pkg::ADDR_W'(rd_row) * bie_pkg::ADDR_W'(bie_pkg::MAX_IN_WIDTH)
      + bie_pkg::ADDR_W'(rd_col));
  assign mem_addr = load_ok ? mem_waddr : mem_raddr;

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      mem_q[mem_addr] <= sample_i;
    end else begin
      mem_rdata_q <= mem_q[mem_addr];
    end
  end

  // blend weights
  assign wgt_h  = mem_sel_q[0] ? {1'b0, xp_q.frac}
                               : (bie_pkg::WGT_W'(1) << bie_pkg::FRAC_BITS) - {1'b0, xp_q.frac};
  assign wgt_v0 = (bie_pkg::WGT_W'(1) << bie_pkg::FRAC_BITS) - {1'b0, yp_q.frac};
  assign hprod  = (bie_pkg::WGT_W+bie_pkg::SAMPLE_W)'(wgt_h)
                  * (bie_pkg::WGT_W+bie_pkg::SAMPLE_W)'(mem_rdata_q);
  assign vsum   = vacc_q + bie_pkg::SUM_W'(bie_pkg::SUM_W'({1'b0, yp_q.frac})
                                            * bie_pkg::SUM_W'(r1_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q   <= bie_pkg::CFG_IN_W'(256);
      in_height_q  <= bie_pkg::CFG_IN_W'(256);
      out_width_q  <= bie_pkg::CFG_OUT_W'(256);
      out_height_q <= bie_pkg::CFG_OUT_W'(256);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bie_pkg::cfg_reg_e'(cfg_index_i))
        bie_pkg::REG_IN_WIDTH:   in_width_q   <= cfg_data_i[bie_pkg::CFG_IN_W-1:0];
        bie_pkg::REG_IN_HEIGHT:  in_height_q  <= cfg_data_i[bie_pkg::CFG_IN_W-1:0];
        bie_pkg::REG_OUT_WIDTH:  out_width_q  <= cfg_data_i[bie_pkg::CFG_OUT_W-1:0];
        bie_pkg::REG_OUT_HEIGHT: out_height_q <= cfg_data_i[bie_pkg::CFG_OUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (func_i == bie_pkg::FUNC_REQ)) begin
      xdiv_q <= '{nq: bie_pkg::DIV_W'(xprod) << bie_pkg::FRAC_BITS, rem: '0};
      ydiv_q <= '{nq: bie_pkg::DIV_W'(yprod) << bie_pkg::FRAC_BITS, rem: '0};
      wo_q   <= wo;
      ho_q   <= ho;
      wi_q   <= wi;
      hi_q   <= hi;
    end else if (state_q == S_DIV) begin
      xdiv_q <= bie_pkg::div_steps(xdiv_q, wo_q);
      ydiv_q <= bie_pkg::div_steps(ydiv_q, ho_q);
    end
    if (state_q == S_POS) begin
      xp_q <= bie_pkg::pos_split(xdiv_q.nq, wi_q);
      yp_q <= bie_pkg::pos_split(ydiv_q.nq, hi_q);
    end
    if (mem_vld_q) begin
      if (!mem_sel_q[0]) begin
        hacc_q <= hprod[bie_pkg::ROW_SUM_W-1:0];
      end else if (!mem_sel_q[1]) begin
        r0_q <= hacc_q + hprod[bie_pkg::ROW_SUM_W-1:0];
      end else begin
        r1_q <= hacc_q + hprod[bie_pkg::ROW_SUM_W-1:0];
      end
    end
    if (state_q == S_V0) begin
      vacc_q <= bie_pkg::SUM_W'(bie_pkg::SUM_W'(wgt_v0) * bie_pkg::SUM_W'(r0_q));
    end
    if (state_q == S_V1) begin
      res_q <= vsum[bie_pkg::SUM_W-1 -: bie_pkg::SAMPLE_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      div_cnt_q    <= '0;
      rd_cnt_q     <= '0;
      mem_vld_q    <= 1'b0;
      mem_sel_q    <= '0;
      out_valid_q  <= 1'b0;
      out_sample_q <= '0;
    end else begin
      mem_vld_q <= (state_q == S_RD);
      mem_sel_q <= rd_cnt_q;
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && (func_i == bie_pkg::FUNC_REQ)) begin
            div_cnt_q <= '0;
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          div_cnt_q <= div_cnt_q + bie_pkg::DIV_CNT_W'(1);
          if (div_cnt_q == bie_pkg::DIV_CNT_W'(bie_pkg::DIV_CYC - 1)) begin
            state_q <= S_POS;
          end
        end
        S_POS: begin
          rd_cnt_q <= '0;
          state_q  <= S_RD;
        end
        S_RD: begin
          rd_cnt_q <= rd_cnt_q + 2'd1;
          if (rd_cnt_q == 2'd3) begin
            state_q <= S_LAST;
          end
        end
        S_LAST: state_q <= S_V0;
        S_V0:   state_q <= S_V1;
        S_V1:   state_q <= S_OUT;
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_sample_q <= res_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NXT(a_req_starts_div, clk_i, rst_ni, in_acc && func_i == bie_pkg::FUNC_REQ, state_q == S_DIV, "request did not enter division")
  `ASSERT_IMP(a_rdata_in_window, clk_i, rst_ni, mem_vld_q, state_q == S_RD || state_q == S_LAST, "frame read data outside read window")
  `ASSERT_IMP(a_result_from_out, clk_i, rst_ni, $rose(out_valid_o), $past(state_q) == S_OUT, "result word appeared without a finished request")
  `ASSERT_IMP(a_div_cnt_bound, clk_i, rst_ni, state_q == S_DIV, div_cnt_q <= bie_pkg::DIV_CNT_W'(bie_pkg::DIV_CYC - 1), "divider step count overran")

endmodule

[sim/bie_enlarge_checker.sv]
module bie_enlarge_checker
  import bie_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  func_i,
  input  logic [PX_W-1:0]       px_i,
  input  logic [PX_W-1:0]       py_i,
  input  logic [SAMPLE_W-1:0]   sample_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [SAMPLE_W-1:0]   out_sample_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           pending_o,
  output int unsigned           mismatches_o
);

  logic [SAMPLE_W-1:0]  plane_mem [DEPTH];
  logic [SAMPLE_W-1:0]  expected_samples [$];
  logic [CFG_IN_W-1:0]  in_w_q;
  logic [CFG_IN_W-1:0]  in_h_q;
  logic [CFG_OUT_W-1:0] out_w_q;
  logic [CFG_OUT_W-1:0] out_h_q;
  logic [SAMPLE_W-1:0]  want;
  int unsigned          mismatch_cnt;

  // zero acts as one, oversized acts as the maximum
  function automatic int unsigned fit_size(int unsigned raw, int unsigned lim);
    if (raw == 0) return 1;
    return (raw > lim) ? lim : raw;
  endfunction

  function automatic longint unsigned texel(int unsigned col, int unsigned row);
    return plane_mem[row * MAX_IN_WIDTH + col];
  endfunction

  // source position in fixed point, neighbours clamped to the last index
  function automatic void src_pos(input logic [PX_W-1:0] p, input int unsigned n_in,
                                  input int unsigned n_out, output int unsigned i0,
                                  output int unsigned i1, output longint unsigned frac);
    longint unsigned pl;
    longint unsigned pos;
    longint unsigned ip;
    longint unsigned last;
    pl   = p;
    pos  = ((pl << FRAC_BITS) * n_in) / n_out;
    ip   = pos >> FRAC_BITS;
    last = n_in - 1;
    frac = pos & ((64'd1 << FRAC_BITS) - 1);
    i0   = (ip > last) ? last : ip;
    i1   = (ip + 1 > last) ? last : ip + 1;
  endfunction

  function automatic logic [SAMPLE_W-1:0] blend_pixel(logic [PX_W-1:0] ox,
                                                      logic [PX_W-1:0] oy);
    int unsigned     x0, x1, y0, y1;
    longint unsigned fx, fy, one, acc;
    src_pos(ox, fit_size(in_w_q, MAX_IN_WIDTH), fit_size(out_w_q, OUT_MAX), x0, x1, fx);
    src_pos(oy, fit_size(in_h_q, MAX_IN_HEIGHT), fit_size(out_h_q, OUT_MAX), y0, y1, fy);
    one = 64'd1 << FRAC_BITS;
    acc = (one - fx) * (one - fy) * texel(x0, y0)
        + fx * (one - fy) * texel(x1, y0)
        + (one - fx) * fy * texel(x0, y1)
        + fx * fy * texel(x1, y1);
    return SAMPLE_W'(acc >> (2 * FRAC_BITS));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_w_q  = CFG_IN_W'(256);
      in_h_q  = CFG_IN_W'(256);
      out_w_q = CFG_OUT_W'(256);
      out_h_q = CFG_OUT_W'(256);
      expected_samples.delete();
      mismatch_cnt = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_IN_WIDTH:   in_w_q  = cfg_data_i[CFG_IN_W-1:0];
          REG_IN_HEIGHT:  in_h_q  = cfg_data_i[CFG_IN_W-1:0];
          REG_OUT_WIDTH:  out_w_q = cfg_data_i[CFG_OUT_W-1:0];
          REG_OUT_HEIGHT: out_h_q = cfg_data_i[CFG_OUT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (func_i == FUNC_LOAD) begin
          if (px_i < fit_size(in_w_q, MAX_IN_WIDTH) && py_i < fit_size(in_h_q, MAX_IN_HEIGHT))
            plane_mem[py_i * MAX_IN_WIDTH + px_i] = sample_i;
        end else begin
          expected_samples.push_back(blend_pixel(px_i, py_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          $display("%0t unexpected word: out_sample expected none, actual %h",
                   $time, out_sample_i);
          mismatch_cnt++;
        end else begin
          want = expected_samples.pop_front();
          if (want !== out_sample_i) begin
            $display("%0t out_sample mismatch: expected %h, actual %h",
                     $time, want, out_sample_i);
            mismatch_cnt++;
          end
        end
      end
    end
    pending_o    <= expected_samples.size();
    mismatches_o <= mismatch_cnt;
  end

endmodule

[sim/tb_top.sv]
module tb_top;
  import bie_pkg::*;

  localparam int unsigned PX_MAX      = (1 << PX_W) - 1;
  localparam int unsigned IN_RAW_MAX  = (1 << CFG_IN_W) - 1;
  localparam int unsigned OUT_RAW_MAX = (1 << CFG_OUT_W) - 1;
  localparam int unsigned RAND_ITEMS  = 1250;
  localparam int unsigned HOLD_CYCLES = 400;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic                  func       = FUNC_LOAD;
  logic [PX_W-1:0]       px         = '0;
  logic [PX_W-1:0]       py         = '0;
  logic [SAMPLE_W-1:0]   sample     = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [SAMPLE_W-1:0]   out_sample;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  cfg_reg_e              cfg_index  = REG_IN_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int unsigned send_max   = 19;
  int unsigned rx_max     = 19;
  int unsigned rx_wait    = 0;
  int unsigned rx_gap;
  int unsigned plane_w    = 256;
  int unsigned plane_h    = 256;
  int unsigned view_w     = 256;
  int unsigned view_h     = 256;
  int unsigned sent_items = 0;
  int unsigned pending;
  int unsigned mismatches;
  logic        hold_go  = 1'b0;
  logic        hold_off = 1'b0;
  bit          written [DEPTH];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bilinear_image_enlarge_unit u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (func),
    .px_i         (px),
    .py_i         (py),
    .sample_i     (sample),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_sample_o (out_sample),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  bie_enlarge_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .func_i       (func),
    .px_i         (px),
    .py_i         (py),
    .sample_i     (sample),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_sample_i (out_sample),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  // result side: random stall after each word, plus one long hold-off
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      rx_gap = $urandom_range(0, rx_max);
      rx_wait   <= rx_gap;
      out_stall <= (rx_gap != 0);
    end else if (rx_wait > 1) begin
      rx_wait <= rx_wait - 1;
    end else begin
      rx_wait   <= 0;
      out_stall <= 1'b0;
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned fit_size(int unsigned raw, int unsigned lim);
    if (raw == 0) return 1;
    return (raw > lim) ? lim : raw;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic put_word(logic f, logic [PX_W-1:0] x, logic [PX_W-1:0] y,
                          logic [SAMPLE_W-1:0] s);
    int unsigned gap;
    gap = $urandom_range(0, send_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    px       <= x;
    py       <= y;
    sample   <= s;
    do @(posedge clk); while (in_stall);
    sent_items++;
    if (f == FUNC_LOAD && x < plane_w && y < plane_h)
      written[y * MAX_IN_WIDTH + x] = 1'b1;
  endtask

  task automatic write_reg(cfg_reg_e r, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_sizes(int unsigned iw, int unsigned ih, int unsigned ow,
                           int unsigned oh);
    write_reg(REG_IN_WIDTH, iw);
    write_reg(REG_IN_HEIGHT, ih);
    write_reg(REG_OUT_WIDTH, ow);
    write_reg(REG_OUT_HEIGHT, oh);
    cfg_valid <= 1'b0;
    plane_w = fit_size(iw, MAX_IN_WIDTH);
    plane_h = fit_size(ih, MAX_IN_HEIGHT);
    view_w  = fit_size(ow, OUT_MAX);
    view_h  = fit_size(oh, OUT_MAX);
  endtask

  // wait until every expected word is back and the block has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  // every neighbour of any request must have been written
  task automatic fill_plane();
    for (int y = 0; y < plane_h; y++)
      for (int x = 0; x < plane_w; x++)
        if (!written[y * MAX_IN_WIDTH + x])
          put_word(FUNC_LOAD, x, y, pick_sample());
  endtask

  task automatic rand_item();
    int unsigned     r;
    logic [PX_W-1:0] x, y;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      x = ($urandom_range(0, 4) == 0) ? $urandom_range(0, PX_MAX)
                                      : $urandom_range(0, view_w - 1);
      y = ($urandom_range(0, 4) == 0) ? $urandom_range(0, PX_MAX)
                                      : $urandom_range(0, view_h - 1);
      put_word(FUNC_REQ, x, y, pick_sample());
    end else if (r < 88) begin
      put_word(FUNC_LOAD, $urandom_range(0, plane_w - 1), $urandom_range(0, plane_h - 1),
               pick_sample());
    end else begin
      if ($urandom_range(0, 1) == 1) begin
        x = $urandom_range(plane_w, PX_MAX);
        y = $urandom_range(0, PX_MAX);
      end else begin
        x = $urandom_range(0, PX_MAX);
        y = $urandom_range(plane_h, PX_MAX);
      end
      put_word(FUNC_LOAD, x, y, pick_sample());
    end
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned n_items;
    int unsigned iw, ih, ow, oh;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tiny plane, odd enlargement, extreme samples and coordinates
    set_sizes(2, 2, 5, 3);
    put_word(FUNC_LOAD, 0, 0, '0);
    put_word(FUNC_LOAD, 1, 0, '1);
    put_word(FUNC_LOAD, 0, 1, '1);
    put_word(FUNC_LOAD, 1, 1, 16'h8001);
    put_word(FUNC_LOAD, 2, 0, 16'h5555);
    put_word(FUNC_LOAD, 0, 2, 16'haaaa);
    put_word(FUNC_LOAD, PX_MAX, PX_MAX, '1);
    put_word(FUNC_REQ, 0, 0, '0);
    put_word(FUNC_REQ, 1, 1, '1);
    put_word(FUNC_REQ, 2, 1, '0);
    put_word(FUNC_REQ, 4, 2, '0);
    put_word(FUNC_REQ, 5, 3, '0);
    put_word(FUNC_REQ, PX_MAX, 0, '0);
    put_word(FUNC_REQ, 0, PX_MAX, '0);
    put_word(FUNC_REQ, PX_MAX, PX_MAX, '0);
    drain();

    // size registers of zero
    set_sizes(0, 0, 0, 0);
    put_word(FUNC_REQ, 0, 0, '0);
    put_word(FUNC_LOAD, 1, 0, 16'h1234);
    put_word(FUNC_REQ, PX_MAX, 1, '0);
    put_word(FUNC_REQ, 3, PX_MAX, '0);
    drain();

    phase_no = 0;
    while (sent_items < RAND_ITEMS) begin
      case (phase_no)
        0: set_sizes(IN_RAW_MAX, 1, OUT_RAW_MAX, 1);
        1: set_sizes(1, MAX_IN_HEIGHT, 1, OUT_MAX);
        2: set_sizes(6, 5, 23, 17);
        default: begin
          iw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
          ih = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
          case ($urandom_range(0, 3))
            0: begin
              ow = $urandom_range(1, OUT_MAX);
              oh = $urandom_range(1, OUT_MAX);
            end
            1: begin
              ow = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(OUT_MAX, OUT_RAW_MAX);
              oh = $urandom_range(0, OUT_RAW_MAX);
            end
            default: begin
              ow = fit_size(iw, MAX_IN_WIDTH) * $urandom_range(1, 8) + $urandom_range(0, 3);
              oh = fit_size(ih, MAX_IN_HEIGHT) * $urandom_range(1, 8) + $urandom_range(0, 3);
            end
          endcase
          set_sizes(iw, ih, ow, oh);
        end
      endcase
      send_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
      rx_max   = ($urandom_range(0, 2) == 0) ? 0 : 19;
      if (phase_no == 2) begin
        send_max = 0;
        rx_max   = 0;
      end
      fill_plane();
      // back up the result side while words keep coming
      if (phase_no == 2) hold_go = 1'b1;
      n_items = $urandom_range(80, 160);
      for (int k = 0; k < n_items; k++) begin
        rand_item();
      end
      drain();
      phase_no++;
    end

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/bie_pkg.sv
design/bilinear_image_enlarge_unit.sv
sim/bie_enlarge_checker.sv
sim/tb_top.sv
